[rtl/core/amf_pkg.sv]
// Shared types, constants and register codes for the alpha morphology filter.
// No dependencies; every other file of the block imports this package.
package amf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_PASSES = 5;
  localparam int FRAC_BITS  = 8;

  localparam int VAL_W  = 8 + FRAC_BITS;           // 8.8 pixel value
  localparam int PRE_W  = VAL_W + 3;               // up to 5x a value, or an 8-term sum
  localparam int EW     = 12;                      // frame_width register
  localparam int HW     = 16;                      // frame_height register
  localparam int AW     = $clog2(MAX_WIDTH);       // line RAM address
  localparam int FILL_W = EW + 1;
  localparam int TOT_W  = EW + HW;
  localparam int NS_W   = 3;

  localparam int SOFT_GAIN_W = 14;
  localparam logic [SOFT_GAIN_W-1:0] SOFT_GAIN = SOFT_GAIN_W'(13107);
  localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(255 << FRAC_BITS);

  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int OF_DEPTH = 32;
  localparam int OF_AW    = $clog2(OF_DEPTH);
  localparam int CNT_W    = OF_AW + 1;

  // operation codes
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_SHAVE   = 3'd1;
  localparam logic [2:0] OP_HSHRINK = 3'd2;
  localparam logic [2:0] OP_SSHRINK = 3'd3;
  localparam logic [2:0] OP_HGROW   = 3'd4;
  localparam logic [2:0] OP_SGROW   = 3'd5;
  localparam logic [2:0] OP_THRESH  = 3'd6;
  localparam logic [2:0] OP_NONE_B  = 3'd7;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OP     = 3'd2;
  localparam logic [2:0] REG_PASSES = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;
  localparam logic [2:0] REG_INVERT = 3'd5;

  typedef struct packed {
    logic [EW-1:0]    w;      // effective width
    logic [HW-1:0]    h;      // effective height
    logic [2:0]       op;
    logic [NS_W-1:0]  ns;     // active stages
    logic [15:0]      thr;
    logic             inv;
    logic [TOT_W-1:0] total;  // pixels per frame
    logic             clr;    // restart frame position
  } cfg_t;

  typedef struct packed {
    logic       flush;
    logic [7:0] alpha;
  } item_t;

  typedef struct packed {
    logic             tok;  // item slot occupied
    logic             vld;  // slot carries a pixel
    logic [VAL_W-1:0] val;
  } link_t;

endpackage

[rtl/core/amf_front.sv]
// Front end: input word queue, configuration registers and APB-style port.
// Depends on amf_pkg.
module amf_front import amf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] alpha_in
  input  logic        in_tuser,     // [0] flush
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output item_t       q_item,
  output logic        q_valid,
  input  logic        q_pop,
  output cfg_t        cfg
);

  item_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0]  q_wr_r, q_rd_r;
  logic [Q_AW:0]    q_cnt_r;
  logic             push;

  logic [EW-1:0]    width_r;
  logic [HW-1:0]    height_r;
  logic [2:0]       op_r;
  logic [2:0]       pass_r;
  logic [15:0]      thr_r;
  logic             inv_r;
  logic [TOT_W-1:0] total_r;
  logic             clr_r;

  logic             wr_en;
  logic [2:0]       idx;
  logic [EW-1:0]    ew;
  logic [HW-1:0]    eh;
  logic [NS_W-1:0]  ns;

  assign in_tready = (q_cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign push      = in_tvalid & in_tready;
  assign q_valid   = (q_cnt_r != '0);
  assign q_item    = q_mem[q_rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr_r] <= '{flush: in_tuser, alpha: in_tdata};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (push) q_wr_r <= q_wr_r + 1'b1;
      if (q_pop) q_rd_r <= q_rd_r + 1'b1;
      q_cnt_r <= q_cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(q_pop);
    end
  end

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= EW'(640);
      height_r <= HW'(480);
      op_r     <= OP_NONE;
      pass_r   <= 3'd1;
      thr_r    <= 16'd32640;
      inv_r    <= 1'b0;
      clr_r    <= 1'b0;
      total_r  <= '0;
    end else begin
      clr_r   <= 1'b0;
      total_r <= TOT_W'(ew) * TOT_W'(eh);
      if (wr_en) begin
        unique case (idx)
          REG_WIDTH:  begin width_r  <= cfg_pwdata[EW-1:0]; clr_r <= 1'b1; end
          REG_HEIGHT: begin height_r <= cfg_pwdata[HW-1:0]; clr_r <= 1'b1; end
          REG_OP:     begin op_r     <= cfg_pwdata[2:0];    clr_r <= 1'b1; end
          REG_PASSES: begin pass_r   <= cfg_pwdata[2:0];    clr_r <= 1'b1; end
          REG_THRESH: thr_r <= cfg_pwdata[15:0];
          REG_INVERT: inv_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  cfg_prdata = 32'(width_r);
      REG_HEIGHT: cfg_prdata = 32'(height_r);
      REG_OP:     cfg_prdata = 32'(op_r);
      REG_PASSES: cfg_prdata = 32'(pass_r);
      REG_THRESH: cfg_prdata = 32'(thr_r);
      REG_INVERT: cfg_prdata = 32'(inv_r);
      default:    cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (width_r < EW'(3)) ew = EW'(3);
    else if (int'(width_r) > MAX_WIDTH) ew = EW'(MAX_WIDTH);
    else ew = width_r;
    eh = (height_r < HW'(3)) ? HW'(3) : height_r;
    if (op_r >= OP_SHAVE && op_r <= OP_SGROW) begin
      ns = (int'(pass_r) > MAX_PASSES) ? NS_W'(MAX_PASSES) : pass_r;
    end else begin
      ns = '0;
    end
  end

  assign cfg = '{w: ew, h: eh, op: op_r, ns: ns, thr: thr_r, inv: inv_r,
                 total: total_r, clr: clr_r};

endmodule

[rtl/core/amf_stage.sv]
// One 3x3 neighborhood pass: two line RAMs, a 3x3 window and a registered pipe of steps A, B, C and D.
// Depends on amf_pkg.
module amf_stage import amf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  en,
  input  link_t din,
  output link_t dout
);

  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_PASS = 3'd1;
  localparam logic [2:0] K_COMP = 3'd2;
  localparam logic [2:0] K_DRAM = 3'd3;  // drain a pixel still in line RAM 1
  localparam logic [2:0] K_DWIN = 3'd4;  // drain the pixel just left RAM 1
  localparam int DW = FILL_W + 1;

  logic [VAL_W-1:0]  mem1 [MAX_WIDTH];
  logic [VAL_W-1:0]  mem2 [MAX_WIDTH];
  logic [VAL_W-1:0]  rd1, rd2;

  logic [FILL_W-1:0] fill_r;
  logic [EW-1:0]     col_r;
  logic [HW-1:0]     row_r;
  logic [TOT_W-1:0]  lin_r;
  logic [AW-1:0]     ptr_r;

  logic              wr, fl, emit_c, drain, border;
  logic [2:0]        kind;
  logic [FILL_W-1:0] w_p1;
  logic [DW-1:0]     dtmp;
  logic [AW-1:0]     daddr, ptr_nxt;

  logic              b_tok_r, b_wr_r;
  logic [2:0]        b_kind_r;
  logic [VAL_W-1:0]  b_val_r;
  logic [AW-1:0]     b_ptr_r;
  logic              b_border_r;

  logic              c_tok_r, c_wr_r;
  logic [2:0]        c_kind_r;
  logic [VAL_W-1:0]  c_val_r, c_mid_r;
  logic              c_border_r;

  logic [VAL_W-1:0]  win_r [3][3];
  logic [VAL_W-1:0]  nwin  [3][3];

  logic              d_tok_r, d_vld_r, d_mul_r;
  logic [PRE_W-1:0]  d_pre_r;

  logic [VAL_W-1:0]  ctr, emn, emx, dmn, dmx;
  logic [PRE_W-1:0]  sum8, pre_nxt;
  logic              vld_nxt, mul_nxt;
  logic [PRE_W+SOFT_GAIN_W-1:0] prod;

  function automatic logic [VAL_W-1:0] vmin(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [VAL_W-1:0] vmax(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // ---- cycle A: write, classify, advance position
  assign w_p1   = FILL_W'(cfg.w) + 1'b1;
  assign wr     = din.tok & din.vld & en;
  assign fl     = din.tok & ~din.vld & en;
  assign emit_c = wr && (fill_r >= w_p1);
  // bubble drains only when every pending pixel belongs to a completed frame
  assign drain  = fl && (fill_r != '0) && ((lin_r + TOT_W'(fill_r)) == cfg.total);
  assign border = (row_r == '0) || (row_r >= cfg.h - 1'b1) ||
                  (col_r == '0) || (col_r >= cfg.w - 1'b1);

  assign dtmp  = DW'(ptr_r) + ((DW'(ptr_r) < DW'(fill_r)) ? DW'(cfg.w) : '0) - DW'(fill_r);
  assign daddr = dtmp[AW-1:0];
  assign ptr_nxt = (EW'(ptr_r) + 1'b1 >= cfg.w) ? '0 : ptr_r + 1'b1;

  always_comb begin
    if (!en) kind = (din.tok & din.vld) ? K_PASS : K_NONE;
    else if (emit_c) kind = K_COMP;
    else if (drain) kind = (fill_r == w_p1) ? K_DWIN : K_DRAM;
    else kind = K_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clr) begin
      fill_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
      lin_r  <= '0;
      ptr_r  <= '0;
    end else begin
      if (wr) begin
        ptr_r <= ptr_nxt;
        if (!emit_c) fill_r <= fill_r + 1'b1;
      end
      if (drain) fill_r <= fill_r - 1'b1;
      if (emit_c || drain) begin
        if (col_r + 1'b1 >= cfg.w) begin
          col_r <= '0;
          if (row_r + 1'b1 >= cfg.h) begin
            row_r <= '0;
            lin_r <= '0;
          end else begin
            row_r <= row_r + 1'b1;
            lin_r <= lin_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
          lin_r <= lin_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      rd1        <= mem1[ptr_r];
      mem1[ptr_r] <= din.val;
    end else if (drain) begin
      rd1 <= mem1[daddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tok_r  <= 1'b0;
      b_wr_r   <= 1'b0;
      b_kind_r <= K_NONE;
    end else begin
      b_tok_r  <= din.tok;
      b_wr_r   <= wr;
      b_kind_r <= kind;
    end
  end

  always_ff @(posedge clk) begin
    b_val_r    <= din.val;
    b_ptr_r    <= ptr_r;
    b_border_r <= border;
  end

  // ---- cycle B: second line delay
  always_ff @(posedge clk) begin
    if (b_wr_r) begin
      rd2           <= mem2[b_ptr_r];
      mem2[b_ptr_r] <= rd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_tok_r  <= 1'b0;
      c_wr_r   <= 1'b0;
      c_kind_r <= K_NONE;
    end else begin
      c_tok_r  <= b_tok_r;
      c_wr_r   <= b_wr_r;
      c_kind_r <= b_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    c_val_r    <= b_val_r;
    c_mid_r    <= rd1;
    c_border_r <= b_border_r;
  end

  // ---- cycle C: window shift and neighborhood math
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nwin[r][0] = win_r[r][1];
      nwin[r][1] = win_r[r][2];
    end
    nwin[0][2] = rd2;
    nwin[1][2] = c_mid_r;
    nwin[2][2] = c_val_r;
  end

  always_ff @(posedge clk) begin
    if (c_wr_r) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= nwin[r][k];
        end
      end
    end
  end

  assign ctr  = nwin[1][1];
  assign emn  = vmin(vmin(vmin(ctr, nwin[0][1]), vmin(nwin[2][1], nwin[1][0])), nwin[1][2]);
  assign emx  = vmax(vmax(vmax(ctr, nwin[0][1]), vmax(nwin[2][1], nwin[1][0])), nwin[1][2]);
  assign dmn  = vmin(vmin(vmin(ctr, nwin[0][0]), vmin(nwin[0][2], nwin[2][0])), nwin[2][2]);
  assign dmx  = vmax(vmax(vmax(ctr, nwin[0][0]), vmax(nwin[0][2], nwin[2][0])), nwin[2][2]);
  assign sum8 = PRE_W'(nwin[0][0]) + PRE_W'(nwin[0][1]) + PRE_W'(nwin[0][2]) +
                PRE_W'(nwin[1][0]) + PRE_W'(nwin[1][2]) +
                PRE_W'(nwin[2][0]) + PRE_W'(nwin[2][1]) + PRE_W'(nwin[2][2]);

  always_comb begin
    vld_nxt = 1'b1;
    mul_nxt = 1'b0;
    pre_nxt = PRE_W'(c_val_r);
    unique case (c_kind_r)
      K_PASS: pre_nxt = PRE_W'(c_val_r);
      K_DRAM: pre_nxt = PRE_W'(c_mid_r);
      K_DWIN: pre_nxt = PRE_W'(win_r[1][2]);
      K_COMP: begin
        pre_nxt = PRE_W'(ctr);
        if (!c_border_r) begin
          unique case (cfg.op)
            OP_SHAVE:   pre_nxt = PRE_W'(vmin(ctr, VAL_W'(sum8 >> 3)));
            OP_HSHRINK: pre_nxt = PRE_W'(emn);
            OP_HGROW:   pre_nxt = PRE_W'(emx);
            OP_SSHRINK: begin
              pre_nxt = (PRE_W'(ctr) << 1) + (PRE_W'(emn) << 1) + PRE_W'(dmn);
              mul_nxt = 1'b1;
            end
            OP_SGROW: begin
              pre_nxt = (PRE_W'(ctr) << 1) + (PRE_W'(emx) << 1) + PRE_W'(dmx);
              mul_nxt = 1'b1;
            end
            default: pre_nxt = PRE_W'(ctr);
          endcase
        end
      end
      default: vld_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_tok_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      d_tok_r <= c_tok_r;
      d_vld_r <= c_tok_r & vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_pre_r <= pre_nxt;
    d_mul_r <= mul_nxt;
  end

  // ---- cycle D: soft gain (x 0.2) and output register
  assign prod = (PRE_W+SOFT_GAIN_W)'(d_pre_r) * (PRE_W+SOFT_GAIN_W)'(SOFT_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout.tok <= 1'b0;
      dout.vld <= 1'b0;
    end else begin
      dout.tok <= d_tok_r;
      dout.vld <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dout.val <= d_mul_r ? prod[16+VAL_W-1:16] : d_pre_r[VAL_W-1:0];
  end

endmodule

[rtl/core/amf_back.sv]
// Back end: stage cascade, threshold and inversion, output word FIFO.
// Depends on amf_pkg and amf_stage.
module amf_back import amf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  item_t       q_item,
  input  logic        q_valid,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] alpha_out
  output logic        out_tlast     // last_of_frame
);

  link_t              link [MAX_PASSES+1];
  logic [CNT_W-1:0]   infl_r, ocnt_r;
  logic [OF_AW-1:0]   owr_r, ord_r;
  logic [8:0]         ofifo [OF_DEPTH];
  logic [TOT_W-1:0]   pos_r;
  logic               p_tok_r, p_vld_r;
  logic [7:0]         p_alpha_r;
  logic [VAL_W-1:0]   v_thr, v_inv;
  logic               push, pop, last;

  // admit an item only when the FIFO is sure to have a slot for it
  assign q_pop = q_valid && ((CNT_W+1)'(infl_r) + (CNT_W+1)'(ocnt_r) < (CNT_W+1)'(OF_DEPTH));

  assign link[0] = '{tok: q_pop, vld: q_pop & ~q_item.flush,
                     val: VAL_W'(q_item.alpha) << FRAC_BITS};

  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
    amf_stage u_stage (
      .clk  (clk),
      .rst_n(rst_n),
      .cfg  (cfg),
      .en   (NS_W'(s) < cfg.ns),
      .din  (link[s]),
      .dout (link[s+1])
    );
  end

  always_comb begin
    v_thr = link[MAX_PASSES].val;
    if (cfg.op == OP_THRESH) begin
      v_thr = ((32'(link[MAX_PASSES].val) << 8) > (32'(cfg.thr) << FRAC_BITS)) ?
              FULL_SCALE : '0;
    end
    v_inv = v_thr;
    if (cfg.inv) v_inv = (v_thr <= FULL_SCALE) ? FULL_SCALE - v_thr : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_tok_r <= 1'b0;
      p_vld_r <= 1'b0;
    end else begin
      p_tok_r <= link[MAX_PASSES].tok;
      p_vld_r <= link[MAX_PASSES].tok & link[MAX_PASSES].vld;
    end
  end

  always_ff @(posedge clk) begin
    p_alpha_r <= v_inv[FRAC_BITS+7:FRAC_BITS];
  end

  assign push = p_tok_r & p_vld_r;
  assign pop  = out_tvalid & out_tready;
  assign last = (pos_r >= cfg.total - 1'b1);

  always_ff @(posedge clk) begin
    if (push) ofifo[owr_r] <= {last, p_alpha_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= '0;
      ocnt_r <= '0;
      owr_r  <= '0;
      ord_r  <= '0;
      pos_r  <= '0;
    end else begin
      infl_r <= infl_r + CNT_W'(q_pop) - CNT_W'(p_tok_r);
      ocnt_r <= ocnt_r + CNT_W'(push) - CNT_W'(pop);
      if (push) owr_r <= owr_r + 1'b1;
      if (pop) ord_r <= ord_r + 1'b1;
      if (cfg.clr) pos_r <= '0;
      else if (push) pos_r <= last ? '0 : pos_r + 1'b1;
    end
  end

  assign out_tvalid = (ocnt_r != '0);
  assign out_tdata  = ofifo[ord_r][7:0];
  assign out_tlast  = ofifo[ord_r][8];

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNT_W+1)'(infl_r) + (CNT_W+1)'(ocnt_r)) <= (CNT_W+1)'(OF_DEPTH))
    else $error("in-flight plus queued words exceed FIFO depth");

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (ocnt_r != CNT_W'(OF_DEPTH)))
    else $error("output FIFO written while full");

  a_exit: assert property (@(posedge clk) disable iff (!rst_n)
    link[MAX_PASSES].tok |=> (infl_r != '0))
    else $error("token left cascade with no item in flight");

endmodule

[rtl/core/alpha_morphology_filter.sv]
// Top level of the alpha morphology filter: front end and back end.
// Depends on amf_pkg, amf_front, amf_back.
// Throughput: one word per cycle on both channels while out_tready stays high.
// Latency: with k active passes a pixel result appears k*(frame_width+1) pixels later,
//   plus steps A to D in each of the 5 physical stages and the queue and output FIFO.
// Flush words push out the tail of a finished frame, one pixel per word.
// Reset: rst_n synchronous active low; line RAMs are not cleared and can be read
//   before being written.
module alpha_morphology_filter import amf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] alpha_in
  input  logic        in_tuser,     // [0] flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] alpha_out
  output logic        out_tlast,    // last_of_frame
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid, q_pop;

  amf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .cfg        (cfg)
  );

  amf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for alpha_morphology_filter: streams raster frames, predicts results.
// Depends on amf_pkg and the filter RTL; nothing else is read or needed.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import amf_pkg::*;

  localparam int RING_LEN = 2 * MAX_WIDTH + 4;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE = 64;

  typedef struct {
    logic [7:0] alpha;
    logic       last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] alpha_in
  logic        in_tuser = 1'b0; // [0] flush
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] alpha_out
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  alpha_morphology_filter dut (.*);

  always #5 clk = ~clk;

  // filter state mirror
  logic [15:0] hist [MAX_PASSES][RING_LEN];
  int unsigned hist_head [MAX_PASSES];
  int unsigned hist_fill [MAX_PASSES];
  int unsigned pos_col [MAX_PASSES];
  int unsigned pos_row [MAX_PASSES];
  int unsigned emitted;
  int unsigned r_width, r_height, r_op, r_passes, r_thresh, r_invert;

  result_t     expected_q [$];
  int          errors = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  task automatic report(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  function automatic int unsigned eff_width();
    if (r_width < 3) return 3;
    if (r_width > MAX_WIDTH) return MAX_WIDTH;
    return r_width;
  endfunction

  function automatic int unsigned eff_height();
    return (r_height < 3) ? 3 : r_height;
  endfunction

  function automatic int unsigned active_stages();
    if (r_op < OP_SHAVE || r_op > OP_SGROW) return 0;
    return (r_passes > MAX_PASSES) ? MAX_PASSES : r_passes;
  endfunction

  function automatic void restart_frame();
    for (int s = 0; s < MAX_PASSES; s++) begin
      hist_fill[s] = 0;
      pos_col[s] = 0;
      pos_row[s] = 0;
    end
    emitted = 0;
  endfunction

  function automatic int unsigned tap(int s, int unsigned o, int off);
    return hist[s][(int'(o) + RING_LEN + off) % RING_LEN];
  endfunction

  function automatic int unsigned lo(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned hi(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

  function automatic int unsigned window_value(int s, int unsigned o, int unsigned w,
                                               int unsigned h);
    int iw;
    int unsigned c, n, so, we, ea, nw, ne, sw, se, e, d;
    longint unsigned mix;
    iw = int'(w);
    c = tap(s, o, 0);
    if (pos_row[s] == 0 || pos_row[s] >= h - 1 || pos_col[s] == 0 || pos_col[s] >= w - 1)
      return c;
    n = tap(s, o, -iw);       so = tap(s, o, iw);
    we = tap(s, o, -1);       ea = tap(s, o, 1);
    nw = tap(s, o, -iw - 1);  ne = tap(s, o, -iw + 1);
    sw = tap(s, o, iw - 1);   se = tap(s, o, iw + 1);
    case (r_op)
      OP_SHAVE: return lo(c, (n + so + we + ea + nw + ne + sw + se) >> 3);
      OP_HSHRINK: return lo(lo(lo(c, n), lo(so, we)), ea);
      OP_HGROW: return hi(hi(hi(c, n), hi(so, we)), ea);
      OP_SSHRINK, OP_SGROW: begin
        if (r_op == OP_SSHRINK) begin
          e = lo(lo(lo(c, n), lo(so, we)), ea);
          d = lo(lo(lo(c, nw), lo(ne, sw)), se);
        end else begin
          e = hi(hi(hi(c, n), hi(so, we)), ea);
          d = hi(hi(hi(c, nw), hi(ne, sw)), se);
        end
        mix = longint'(2 * c + 2 * e + d) * 13107;
        return int'(mix >> 16);
      end
      default: return c;
    endcase
  endfunction

  function automatic int unsigned pop_oldest(int s, int unsigned w, int unsigned h);
    int unsigned o, v;
    o = (hist_head[s] + RING_LEN - hist_fill[s]) % RING_LEN;
    v = window_value(s, o, w, h);
    pos_col[s]++;
    if (pos_col[s] >= w) begin
      pos_col[s] = 0;
      pos_row[s]++;
      if (pos_row[s] >= h) pos_row[s] = 0;
    end
    hist_fill[s]--;
    return v;
  endfunction

  // advance the mirror by one accepted word, queue the result it causes, if any
  function automatic void predict_word(logic [7:0] alpha, logic flush);
    int unsigned w, h, ns, v, total;
    bit live;
    result_t r;
    w = eff_width();
    h = eff_height();
    ns = active_stages();
    total = w * h;
    live = !flush;
    v = int'(alpha) << FRAC_BITS;
    for (int s = 0; s < ns; s++) begin
      if (live) begin
        hist[s][hist_head[s]] = v[15:0];
        hist_head[s] = (hist_head[s] + 1) % RING_LEN;
        hist_fill[s]++;
        if (hist_fill[s] > w + 1) v = pop_oldest(s, w, h);
        else live = 0;
      end else if (hist_fill[s] > 0 &&
                   (pos_row[s] * w + pos_col[s] + hist_fill[s]) % total == 0) begin
        v = pop_oldest(s, w, h);
        live = 1;
      end
    end
    if (!live) return;
    if (r_op == OP_THRESH) v = (v > r_thresh) ? int'(FULL_SCALE) : 0;
    if (r_invert != 0) v = (v <= FULL_SCALE) ? int'(FULL_SCALE) - v : 0;
    r.alpha = v[15:8];
    r.last = (emitted >= total - 1);
    emitted = r.last ? 0 : emitted + 1;
    expected_q.push_back(r);
  endfunction

  function automatic void apply_register(int unsigned idx, logic [31:0] val);
    case (idx)
      REG_WIDTH:  begin r_width = val[11:0]; restart_frame(); end
      REG_HEIGHT: begin r_height = val[15:0]; restart_frame(); end
      REG_OP:     begin r_op = val[2:0]; restart_frame(); end
      REG_PASSES: begin r_passes = val[2:0]; restart_frame(); end
      REG_THRESH: r_thresh = val[15:0];
      REG_INVERT: r_invert = val[0];
      default: ;
    endcase
  endfunction

  // monitors: input words, register writes, results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_word(in_tdata, in_tuser);
        words_in++;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        apply_register(cfg_paddr >> 2, cfg_pwdata);
      if (out_tvalid && out_tready) begin
        words_out++;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result alpha=%0d last=%0b", out_tdata, out_tlast));
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (out_tdata !== e.alpha)
            report($sformatf("alpha got %0d want %0d", out_tdata, e.alpha));
          if (out_tlast !== e.last)
            report($sformatf("last got %0b want %0b", out_tlast, e.last));
        end
      end
    end
  end

  // receiver stall pattern: out_tready follows one of four randomly chosen modes
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ((stall_tick / 5) % 2 == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] alpha, input logic flush);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_tvalid <= 1'b1;
    in_tdata <= alpha;
    in_tuser <= flush;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic setup(int unsigned w, int unsigned h, logic [2:0] op, int unsigned passes);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_OP, op);
    write_reg(REG_PASSES, passes);
  endtask

  // one frame of pixels, then enough flush words to push out the tail
  task automatic send_frame(int unsigned style);
    int unsigned w, h, base;
    logic [7:0] a;
    w = eff_width();
    h = eff_height();
    base = $urandom_range(0, 255);
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        case (style)
          0: a = $urandom_range(0, 255);
          1: a = (x > 0 && x < w - 1 && y > 0 && y < h - 1 && (x + y) % 3 != 0) ? 8'hFF : 8'h00;
          2: a = base;
          default: a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
                       (((x ^ y) & 1) ? 8'hFF : 8'h00);
        endcase
        send_word(a, 1'b0);
      end
    end
    repeat (active_stages() * (w + 1) + 2) send_word(8'h00, 1'b1);
  endtask

  task automatic test_defaults();
    // out of reset: no operation, pointwise, no flush results
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'hA5, 1'b0);
    drain();
  endtask

  task automatic test_pointwise();
    logic [15:0] levels [4] = '{16'd0, 16'd32768, 16'd65280, 16'd65535};
    write_reg(REG_OP, OP_THRESH);
    foreach (levels[i]) begin
      write_reg(REG_THRESH, levels[i]);
      write_reg(REG_INVERT, i % 2);
      send_word(8'h00, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h81, 1'b0);
      send_word(8'hFF, 1'b0);
      drain();
    end
    setup(3, 3, OP_NONE_B, 2);
    send_frame(0);
    drain();
    write_reg(REG_INVERT, 0);
  endtask

  task automatic test_each_operation();
    for (int op = OP_SHAVE; op <= OP_SGROW; op++) begin
      setup(5, 4, op, 1);
      send_frame(1);
      send_frame(0);
      drain();
    end
    // no stages, clamped pass count, clamped width and height
    setup(4, 3, OP_HGROW, 0);
    send_frame(0);
    drain();
    setup(1, 0, OP_SGROW, 7);
    send_frame(3);
    drain();
  endtask

  task automatic test_midframe_flush();
    setup(4, 4, OP_HSHRINK, 2);
    repeat (6) send_word($urandom_range(0, 255), 1'b0);
    repeat (3) send_word(8'h00, 1'b1);
    repeat (10) send_word($urandom_range(0, 255), 1'b0);
    repeat (12) send_word(8'h00, 1'b1);
    send_frame(2);
    drain();
  endtask

  task automatic test_wide_and_tall();
    setup(100, 3, OP_SHAVE, 1);
    send_frame(0);
    drain();
    setup(4095, 65535, OP_NONE, 5);
    repeat (8) send_word($urandom_range(0, 255), 1'b0);
    drain();
  endtask

  task automatic test_random(int unsigned target);
    while (words_in < target) begin
      setup($urandom_range(3, 10), $urandom_range(3, 6), $urandom_range(0, 7),
            $urandom_range(0, 7));
      write_reg(REG_THRESH, $urandom_range(0, 65535));
      write_reg(REG_INVERT, $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        // broken sequence: stray flushes and a partial frame
        repeat ($urandom_range(1, 20)) send_word($urandom_range(0, 255), $urandom_range(0, 1));
      end
      repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 3));
      drain();
    end
  endtask

  initial begin
    for (int s = 0; s < MAX_PASSES; s++) begin
      hist_head[s] = 0;
      for (int i = 0; i < RING_LEN; i++) hist[s][i] = '0;
    end
    r_width = 640; r_height = 480; r_op = OP_NONE; r_passes = 1;
    r_thresh = 32640; r_invert = 0;
    restart_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_pointwise();
    test_each_operation();
    test_midframe_flush();
    test_wide_and_tall();
    test_random(1250);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (expected_q.size() != 0) report("expected results left over");
    $display("Covered: %0d input words, %0d results, all operations, pass counts 0..7,",
             words_in, words_out);
    $display("threshold and invert extremes, clamped sizes and mid-frame flushes.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
